FILE: hw/rtl/ubd_pkg.sv
// Package for the UART baud divisor calculator.
// Holds the fixed widths, the modulation threshold table and shared types.
// No dependencies.
`timescale 1ns / 1ps

package ubd_pkg;

  // Widths fixed by the input and output fields.
  localparam int unsigned SEL_W   = 3;
  localparam int unsigned BAUD_W  = 23;
  // The clock reaches 1500000 << 7, which needs 28 bits.
  localparam int unsigned CLK_W   = 28;
  // The divisor is at most 16 times the baud rate.
  localparam int unsigned DIVR_W  = BAUD_W + 4;
  localparam int unsigned PRE_W   = 16;
  localparam int unsigned FMOD_W  = 4;
  localparam int unsigned SMOD_W  = 8;

  localparam logic [CLK_W-1:0] BASE_CLOCK_HZ = 28'd1500000;
  localparam logic [PRE_W-1:0] PRESCALER_MAX = 16'hFFFF;

  // Thresholds are given in units of 1/10000 and rounded half up.
  localparam logic [63:0] THRESH_SCALE = 64'd10000;
  localparam logic [63:0] THRESH_ROUND = 64'd5000;

  localparam int unsigned STEP_COUNT = 35;

  // Fraction thresholds, largest first, in units of 1/10000.
  localparam logic [13:0] STEP_TENK [STEP_COUNT] = '{
    14'd9288, 14'd9170, 14'd9004, 14'd8751, 14'd8572, 14'd8464, 14'd8333,
    14'd8004, 14'd7861, 14'd7503, 14'd7147, 14'd7001, 14'd6667, 14'd6432,
    14'd6254, 14'd6003, 14'd5715, 14'd5002, 14'd4378, 14'd4286, 14'd4003,
    14'd3753, 14'd3575, 14'd3335, 14'd3000, 14'd2503, 14'd2224, 14'd2147,
    14'd1670, 14'd1430, 14'd1252, 14'd1001, 14'd835,  14'd715,  14'd529
  };

  // Bit modulation pattern that belongs to each threshold.
  localparam logic [SMOD_W-1:0] STEP_PAT [STEP_COUNT] = '{
    8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF,
    8'hEE, 8'hED, 8'hDD, 8'hBB, 8'hB7, 8'hD6, 8'hB6,
    8'hB5, 8'hAD, 8'h6B, 8'hAA, 8'h55, 8'h53, 8'h92,
    8'h52, 8'h4A, 8'h49, 8'h25, 8'h44, 8'h22, 8'h21,
    8'h11, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01
  };

  // Side band that travels with each item down the divider chain.
  typedef struct packed {
    logic valid;
    logic over;
    logic zero;
  } ubd_meta_t;

  // One finished set of divider settings.
  typedef struct packed {
    logic [PRE_W-1:0]  prescaler;
    logic [FMOD_W-1:0] first_mod;
    logic [SMOD_W-1:0] second_mod;
    logic              over;
    logic              ovf;
  } ubd_res_t;

  // Scales a threshold to a fraction with fb fraction bits, rounding half up.
  // Only used on constants, so it folds at elaboration.
  function automatic logic [31:0] thresh_scaled(input logic [13:0] tenk,
                                                input int unsigned fb);
    logic [63:0] v;
    v = ((64'(tenk) << fb) + THRESH_ROUND) / THRESH_SCALE;
    return v[31:0];
  endfunction

endpackage

FILE: hw/rtl/ubd_prep.sv
// Entry stage of the baud divisor calculator: builds the dividend and divisor.
// Depends on ubd_pkg.
`timescale 1ns / 1ps

module ubd_prep
  import ubd_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [SEL_W-1:0]              sel_i,
  input  logic [BAUD_W-1:0]             baud_i,
  output ubd_meta_t                     meta_o,
  output logic [DIVR_W-1:0]             rem_o,
  output logic [CLK_W+FRAC_BITS-1:0]    dq_o,
  output logic [DIVR_W-1:0]             div_o
);

  localparam int unsigned DW = CLK_W + FRAC_BITS;

  logic [CLK_W-1:0]  clock;
  logic [DIVR_W-1:0] baud16;
  ubd_meta_t         meta_d, meta_q;
  logic [DW-1:0]     dq_d, dq_q;
  logic [DIVR_W-1:0] div_d, div_q;

  // Oversampling is decided exactly, on the clock against sixteen baud periods.
  always_comb begin
    clock       = BASE_CLOCK_HZ << sel_i;
    baud16      = {baud_i, 4'b0000};
    meta_d.valid = valid_i;
    meta_d.over  = (clock > {1'b0, baud16});
    meta_d.zero  = (baud_i == '0);
    div_d        = meta_d.over ? baud16 : {4'b0000, baud_i};
    dq_d         = {clock, {FRAC_BITS{1'b0}}};
  end

  // Only the valid bit needs a reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else if (en_i) begin
      meta_q <= meta_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dq_q  <= dq_d;
      div_q <= div_d;
    end
  end

  assign meta_o = meta_q;
  assign rem_o  = '0;
  assign dq_o   = dq_q;
  assign div_o  = div_q;

endmodule

FILE: hw/rtl/ubd_div_cell.sv
// One cell of the restoring divider chain: resolves one quotient bit per item.
// Depends on ubd_pkg.
`timescale 1ns / 1ps

module ubd_div_cell
  import ubd_pkg::*;
#(
  parameter int unsigned DW = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  ubd_meta_t         meta_i,
  input  logic [DIVR_W-1:0] rem_i,
  input  logic [DW-1:0]     dq_i,
  input  logic [DIVR_W-1:0] div_i,
  output ubd_meta_t         meta_o,
  output logic [DIVR_W-1:0] rem_o,
  output logic [DW-1:0]     dq_o,
  output logic [DIVR_W-1:0] div_o
);

  logic [DIVR_W:0]   trial;
  logic              qbit;
  logic [DIVR_W-1:0] rem_d, rem_q;
  logic [DW-1:0]     dq_d, dq_q;
  ubd_meta_t         meta_q;
  logic [DIVR_W-1:0] div_q;

  // Shift the next dividend bit into the remainder and try a subtraction.
  // The quotient bit enters at the bottom of the dividend word.
  always_comb begin
    trial = {rem_i, dq_i[DW-1]};
    qbit  = (trial >= {1'b0, div_i});
    if (qbit) begin
      rem_d = DIVR_W'(trial - {1'b0, div_i});
    end else begin
      rem_d = trial[DIVR_W-1:0];
    end
    dq_d = {dq_i[DW-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else if (en_i) begin
      meta_q <= meta_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
      div_q <= div_i;
    end
  end

  assign meta_o = meta_q;
  assign rem_o  = rem_q;
  assign dq_o   = dq_q;
  assign div_o  = div_q;

endmodule

FILE: hw/rtl/ubd_post.sv
// Result stage: saturates the prescaler and picks the modulation values.
// Depends on ubd_pkg.
`timescale 1ns / 1ps

module ubd_post
  import ubd_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 20
) (
  input  ubd_meta_t                  meta_i,
  input  logic [CLK_W+FRAC_BITS-1:0] quot_i,
  output ubd_res_t                   res_o
);

  localparam int unsigned DW = CLK_W + FRAC_BITS;

  logic [CLK_W-1:0]     ipart;
  logic [FRAC_BITS-1:0] frac;
  logic [STEP_COUNT-1:0] hit;
  logic [SMOD_W-1:0]    pattern;
  logic                 ovf;

  assign ipart = quot_i[DW-1:FRAC_BITS];
  assign frac  = quot_i[FRAC_BITS-1:0];

  // Compare the fraction against every scaled threshold in parallel.
  for (genvar i = 0; i < STEP_COUNT; i++) begin : g_thr
    localparam logic [FRAC_BITS:0] Thr =
      (FRAC_BITS+1)'(thresh_scaled(STEP_TENK[i], FRAC_BITS));
    assign hit[i] = ({1'b0, frac} >= Thr);
  end

  // The largest threshold that the fraction reaches wins.
  always_comb begin
    pattern = '0;
    for (int i = STEP_COUNT - 1; i >= 0; i--) begin
      if (hit[i]) begin
        pattern = STEP_PAT[i];
      end
    end
  end

  assign ovf = |ipart[CLK_W-1:PRE_W];

  // A zero baud rate reads as an infinite quotient.
  always_comb begin
    if (meta_i.zero) begin
      res_o.prescaler  = PRESCALER_MAX;
      res_o.first_mod  = '0;
      res_o.second_mod = '0;
      res_o.over       = 1'b1;
      res_o.ovf        = 1'b1;
    end else begin
      res_o.prescaler  = ovf ? PRESCALER_MAX : ipart[PRE_W-1:0];
      res_o.first_mod  = meta_i.over ? frac[FRAC_BITS-1 -: FMOD_W] : '0;
      res_o.second_mod = pattern;
      res_o.over       = meta_i.over;
      res_o.ovf        = ovf;
    end
  end

endmodule

FILE: hw/rtl/uart_baud_divisor_calculator.sv
// Top level of the UART baud divisor calculator.
// Depends on ubd_pkg, ubd_prep, ubd_div_cell and ubd_post.
`timescale 1ns / 1ps

// Usage:
// A request (clock_range_select_i, baud_rate_i) is a transfer on the input
// channel when in_valid_i and in_ready_o are both high. Each request gives
// exactly one transfer of divider settings on the output channel, in order.
// The clock is 1.5 MHz shifted left by the select; the quotient clock/divisor
// carries FRAC_BITS fraction bits.
// From input transfer to output valid, a request passes one entry stage, one
// restoring divider cell per quotient bit (28 + FRAC_BITS cells) and the output
// register. Throughput is one request per cycle while the skid register is
// empty; every divider cell resolves one quotient bit and hands its remainder
// to the next cell each cycle that the chain moves.
// A skid register sits behind the output register. When the receiver stalls,
// the next result lands in the skid register and in_ready_o drops while it is
// full; the whole chain then holds until the output is taken.
// Reset clears all valid bits; the block is ready right after reset.
module uart_baud_divisor_calculator
  import ubd_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SEL_W-1:0]     clock_range_select_i,
  input  logic [BAUD_W-1:0]    baud_rate_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PRE_W-1:0]     prescaler_o,
  output logic [FMOD_W-1:0]    first_modulation_o,
  output logic [SMOD_W-1:0]    second_modulation_o,
  output logic                 oversampling_o,
  output logic                 overflow_o
);

  localparam int unsigned DW = CLK_W + FRAC_BITS;

  logic              en;
  ubd_meta_t         meta_s [DW+1];
  logic [DIVR_W-1:0] rem_s  [DW+1];
  logic [DW-1:0]     dq_s   [DW+1];
  logic [DIVR_W-1:0] div_s  [DW+1];
  ubd_res_t          res;
  logic              out_vld_d, out_vld_q, skid_vld_d, skid_vld_q;
  ubd_res_t          out_d, out_q, skid_d, skid_q;

  // The chain moves whenever the skid register is free.
  assign en         = !skid_vld_q;
  assign in_ready_o = en;

  ubd_prep #(
    .FRAC_BITS (FRAC_BITS)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .sel_i   (clock_range_select_i),
    .baud_i  (baud_rate_i),
    .meta_o  (meta_s[0]),
    .rem_o   (rem_s[0]),
    .dq_o    (dq_s[0]),
    .div_o   (div_s[0])
  );

  // One divider cell per quotient bit.
  for (genvar k = 0; k < DW; k++) begin : g_cell
    ubd_div_cell #(
      .DW (DW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .meta_i (meta_s[k]),
      .rem_i  (rem_s[k]),
      .dq_i   (dq_s[k]),
      .div_i  (div_s[k]),
      .meta_o (meta_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .dq_o   (dq_s[k+1]),
      .div_o  (div_s[k+1])
    );
  end

  ubd_post #(
    .FRAC_BITS (FRAC_BITS)
  ) u_post (
    .meta_i (meta_s[DW]),
    .quot_i (dq_s[DW]),
    .res_o  (res)
  );

  // Output register with a skid register behind it.
  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (out_ready_i) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (out_vld_q && !out_ready_i) begin
      if (meta_s[DW].valid) begin
        skid_d     = res;
        skid_vld_d = 1'b1;
      end
    end else begin
      out_vld_d = meta_s[DW].valid;
      out_d     = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o         = out_vld_q;
  assign prescaler_o         = out_q.prescaler;
  assign first_modulation_o  = out_q.first_mod;
  assign second_modulation_o = out_q.second_mod;
  assign oversampling_o      = out_q.over;
  assign overflow_o          = out_q.ovf;

  // The skid register only fills behind a held output.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register full while output register empty");

  // The skid register fills only when the receiver stalled a valid output.
  a_skid_fill_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !out_ready_i))
    else $error("skid register filled without a stall");

  // A saturated prescaler reads as all ones.
  a_ovf_saturates : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && overflow_o) |-> (prescaler_o == PRESCALER_MAX))
    else $error("overflow set without a saturated prescaler");

  // Without oversampling the quotient is at most sixteen and has no first value.
  a_plain_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !oversampling_o) |->
      (prescaler_o <= 16'd16 && first_modulation_o == '0 && !overflow_o))
    else $error("plain mode result out of range");

endmodule
